// ===== rtl/hkrt_pkg.sv =====
// Shared types, constants and key table of the HID keyboard report tracker.
package hkrt_pkg;

  localparam int unsigned USAGE_COUNT_DEF = 256;
  localparam int unsigned MAX_EVENTS_DEF  = 64;
  localparam int unsigned ROW_BITS        = 16;
  localparam int unsigned BIT_W           = 4;
  localparam int unsigned ROW_MAX_W       = 4;

  localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
  localparam logic [15:0] USAGE_FIRST   = 16'd4;

  localparam logic [7:0] KEY_LSHIFT = 8'hE1;
  localparam logic [7:0] KEY_RSHIFT = 8'hE5;
  localparam logic [7:0] KEY_LCTRL  = 8'hE0;
  localparam logic [7:0] KEY_RCTRL  = 8'hE4;
  localparam logic [7:0] KEY_LALT   = 8'hE2;
  localparam logic [7:0] KEY_RALT   = 8'hE6;
  localparam logic [7:0] KEY_CAPS   = 8'h39;
  localparam logic [7:0] KEY_SCROLL = 8'h47;
  localparam logic [7:0] KEY_NUM    = 8'h53;

  localparam logic [15:0] DELAY_RESET  = 16'd500;
  localparam logic [15:0] PERIOD_RESET = 16'd50;

  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [1:0] GRP_NORMAL = 2'd0;
  localparam logic [1:0] GRP_FUNC   = 2'd1;
  localparam logic [1:0] GRP_NUMPAD = 2'd2;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0,
    CMD_ARRAY = 3'd1,
    CMD_VAR   = 3'd2,
    CMD_END   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] page;
    logic [15:0] usage;
    logic        usage_on;
  } in_t;

  typedef struct packed {
    logic [1:0] key_group;
    logic [2:0] key_row;
    logic [4:0] key_col;
    logic [8:0] modifiers;
    logic       pressed;
    logic       from_repeat;
    logic       last;
    logic       overflow;
  } out_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           group;
    logic [2:0]           row;
    logic [4:0]           col;
  } keymap_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_MAX_W-1:0] rd_row;
    logic                 rpt_we;
    logic                 held_we;
    logic [ROW_MAX_W-1:0] wr_row;
    logic [ROW_BITS-1:0]  wdata;
    logic                 rpt_clr;
  } mem_req_t;

  function automatic keymap_t km(input logic [1:0] g, input logic [2:0] r,
                                 input logic [4:0] c);
    km = keymap_t'{1'b1, g, r, c};
  endfunction

  function automatic keymap_t keymap(input logic [7:0] k);
    keymap_t m;
    m = '0;
    case (k)
      8'h35: m = km(GRP_NORMAL, 3'd0, 5'd0);
      8'h1E: m = km(GRP_NORMAL, 3'd0, 5'd1);
      8'h1F: m = km(GRP_NORMAL, 3'd0, 5'd2);
      8'h20: m = km(GRP_NORMAL, 3'd0, 5'd3);
      8'h21: m = km(GRP_NORMAL, 3'd0, 5'd4);
      8'h22: m = km(GRP_NORMAL, 3'd0, 5'd5);
      8'h23: m = km(GRP_NORMAL, 3'd0, 5'd6);
      8'h24: m = km(GRP_NORMAL, 3'd0, 5'd7);
      8'h25: m = km(GRP_NORMAL, 3'd0, 5'd8);
      8'h26: m = km(GRP_NORMAL, 3'd0, 5'd9);
      8'h27: m = km(GRP_NORMAL, 3'd0, 5'd10);
      8'h2D: m = km(GRP_NORMAL, 3'd0, 5'd11);
      8'h2E: m = km(GRP_NORMAL, 3'd0, 5'd12);
      8'h2A: m = km(GRP_NORMAL, 3'd0, 5'd13);
      8'h2B: m = km(GRP_NORMAL, 3'd1, 5'd0);
      8'h14: m = km(GRP_NORMAL, 3'd1, 5'd1);
      8'h1A: m = km(GRP_NORMAL, 3'd1, 5'd2);
      8'h08: m = km(GRP_NORMAL, 3'd1, 5'd3);
      8'h15: m = km(GRP_NORMAL, 3'd1, 5'd4);
      8'h17: m = km(GRP_NORMAL, 3'd1, 5'd5);
      8'h1C: m = km(GRP_NORMAL, 3'd1, 5'd6);
      8'h18: m = km(GRP_NORMAL, 3'd1, 5'd7);
      8'h0C: m = km(GRP_NORMAL, 3'd1, 5'd8);
      8'h12: m = km(GRP_NORMAL, 3'd1, 5'd9);
      8'h13: m = km(GRP_NORMAL, 3'd1, 5'd10);
      8'h2F: m = km(GRP_NORMAL, 3'd1, 5'd11);
      8'h30: m = km(GRP_NORMAL, 3'd1, 5'd12);
      8'h39: m = km(GRP_NORMAL, 3'd2, 5'd0);
      8'h04: m = km(GRP_NORMAL, 3'd2, 5'd1);
      8'h16: m = km(GRP_NORMAL, 3'd2, 5'd2);
      8'h07: m = km(GRP_NORMAL, 3'd2, 5'd3);
      8'h09: m = km(GRP_NORMAL, 3'd2, 5'd4);
      8'h0A: m = km(GRP_NORMAL, 3'd2, 5'd5);
      8'h0B: m = km(GRP_NORMAL, 3'd2, 5'd6);
      8'h0D: m = km(GRP_NORMAL, 3'd2, 5'd7);
      8'h0E: m = km(GRP_NORMAL, 3'd2, 5'd8);
      8'h0F: m = km(GRP_NORMAL, 3'd2, 5'd9);
      8'h33: m = km(GRP_NORMAL, 3'd2, 5'd10);
      8'h34: m = km(GRP_NORMAL, 3'd2, 5'd11);
      8'h31: m = km(GRP_NORMAL, 3'd2, 5'd12);
      8'h28: m = km(GRP_NORMAL, 3'd2, 5'd13);
      8'hE1: m = km(GRP_NORMAL, 3'd3, 5'd0);
      8'h64: m = km(GRP_NORMAL, 3'd3, 5'd1);
      8'h1D: m = km(GRP_NORMAL, 3'd3, 5'd2);
      8'h1B: m = km(GRP_NORMAL, 3'd3, 5'd3);
      8'h06: m = km(GRP_NORMAL, 3'd3, 5'd4);
      8'h19: m = km(GRP_NORMAL, 3'd3, 5'd5);
      8'h05: m = km(GRP_NORMAL, 3'd3, 5'd6);
      8'h11: m = km(GRP_NORMAL, 3'd3, 5'd7);
      8'h10: m = km(GRP_NORMAL, 3'd3, 5'd8);
      8'h36: m = km(GRP_NORMAL, 3'd3, 5'd9);
      8'h37: m = km(GRP_NORMAL, 3'd3, 5'd10);
      8'h38: m = km(GRP_NORMAL, 3'd3, 5'd11);
      8'hE5: m = km(GRP_NORMAL, 3'd3, 5'd12);
      8'hE0: m = km(GRP_NORMAL, 3'd4, 5'd0);
      8'hE3: m = km(GRP_NORMAL, 3'd4, 5'd1);
      8'hE2: m = km(GRP_NORMAL, 3'd4, 5'd2);
      8'h2C: m = km(GRP_NORMAL, 3'd4, 5'd3);
      8'hE6: m = km(GRP_NORMAL, 3'd4, 5'd5);
      8'hE4: m = km(GRP_NORMAL, 3'd4, 5'd6);
      8'h52: m = km(GRP_NORMAL, 3'd5, 5'd0);
      8'h50: m = km(GRP_NORMAL, 3'd5, 5'd1);
      8'h51: m = km(GRP_NORMAL, 3'd5, 5'd2);
      8'h4F: m = km(GRP_NORMAL, 3'd5, 5'd3);
      8'h29: m = km(GRP_FUNC, 3'd0, 5'd0);
      8'h3A: m = km(GRP_FUNC, 3'd0, 5'd1);
      8'h3B: m = km(GRP_FUNC, 3'd0, 5'd2);
      8'h3C: m = km(GRP_FUNC, 3'd0, 5'd3);
      8'h3D: m = km(GRP_FUNC, 3'd0, 5'd4);
      8'h3E: m = km(GRP_FUNC, 3'd0, 5'd5);
      8'h3F: m = km(GRP_FUNC, 3'd0, 5'd6);
      8'h40: m = km(GRP_FUNC, 3'd0, 5'd7);
      8'h41: m = km(GRP_FUNC, 3'd0, 5'd8);
      8'h42: m = km(GRP_FUNC, 3'd0, 5'd9);
      8'h43: m = km(GRP_FUNC, 3'd0, 5'd10);
      8'h44: m = km(GRP_FUNC, 3'd0, 5'd11);
      8'h45: m = km(GRP_FUNC, 3'd0, 5'd12);
      8'h49: m = km(GRP_FUNC, 3'd0, 5'd13);
      8'h46: m = km(GRP_FUNC, 3'd0, 5'd14);
      8'h4C: m = km(GRP_FUNC, 3'd0, 5'd15);
      8'h4A: m = km(GRP_FUNC, 3'd0, 5'd16);
      8'h4D: m = km(GRP_FUNC, 3'd0, 5'd17);
      8'h4B: m = km(GRP_FUNC, 3'd0, 5'd18);
      8'h4E: m = km(GRP_FUNC, 3'd0, 5'd19);
      8'h47: m = km(GRP_FUNC, 3'd0, 5'd20);
      8'h53: m = km(GRP_NUMPAD, 3'd0, 5'd0);
      8'h54: m = km(GRP_NUMPAD, 3'd0, 5'd1);
      8'h55: m = km(GRP_NUMPAD, 3'd0, 5'd2);
      8'h56: m = km(GRP_NUMPAD, 3'd0, 5'd3);
      8'h5F: m = km(GRP_NUMPAD, 3'd1, 5'd0);
      8'h60: m = km(GRP_NUMPAD, 3'd1, 5'd1);
      8'h61: m = km(GRP_NUMPAD, 3'd1, 5'd2);
      8'h57: m = km(GRP_NUMPAD, 3'd1, 5'd3);
      8'h5C: m = km(GRP_NUMPAD, 3'd2, 5'd0);
      8'h5D: m = km(GRP_NUMPAD, 3'd2, 5'd1);
      8'h5E: m = km(GRP_NUMPAD, 3'd2, 5'd2);
      8'h59: m = km(GRP_NUMPAD, 3'd3, 5'd0);
      8'h5A: m = km(GRP_NUMPAD, 3'd3, 5'd1);
      8'h5B: m = km(GRP_NUMPAD, 3'd3, 5'd2);
      8'h58: m = km(GRP_NUMPAD, 3'd3, 5'd3);
      8'h62: m = km(GRP_NUMPAD, 3'd4, 5'd0);
      8'h63: m = km(GRP_NUMPAD, 3'd4, 5'd1);
      default: m = '0;
    endcase
    keymap = m;
  endfunction

  function automatic logic repeatable(input logic [7:0] k);
    logic r;
    r = 1'b1;
    if (k <= 8'h03 || k == 8'h29 || k == KEY_CAPS || k == KEY_SCROLL || k == KEY_NUM) begin
      r = 1'b0;
    end
    if (k >= 8'h3A && k <= 8'h45) begin
      r = 1'b0;
    end
    if (k >= 8'hE0 && k <= 8'hE7) begin
      r = 1'b0;
    end
    repeatable = r;
  endfunction

  function automatic logic [ROW_BITS-1:0] map_mask(input logic [ROW_MAX_W-1:0] row);
    logic [ROW_BITS-1:0] m;
    for (int j = 0; j < ROW_BITS; j++) begin
      m[j] = keymap({row, BIT_W'(j)}).valid;
    end
    map_mask = m;
  endfunction

  function automatic logic [ROW_BITS-1:0] rep_mask(input logic [ROW_MAX_W-1:0] row);
    logic [ROW_BITS-1:0] m;
    for (int j = 0; j < ROW_BITS; j++) begin
      m[j] = repeatable({row, BIT_W'(j)});
    end
    rep_mask = m;
  endfunction

  function automatic logic [BIT_W-1:0] low_bit(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (v[j]) b = BIT_W'(j);
    end
    low_bit = b;
  endfunction

  function automatic logic [BIT_W-1:0] high_bit(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      if (v[j]) b = BIT_W'(j);
    end
    high_bit = b;
  endfunction

  function automatic logic [BIT_W:0] pop16(input logic [ROW_BITS-1:0] v);
    logic [BIT_W:0] c;
    c = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      c = c + (BIT_W + 1)'(v[j]);
    end
    pop16 = c;
  endfunction

endpackage

// ===== rtl/hkrt_keymem.sv =====
// Report and held key bitmaps, kept as two row memories with row valid flags.
module hkrt_keymem #(
  parameter int unsigned ROWS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hkrt_pkg::mem_req_t                   req_i,
  output logic [hkrt_pkg::ROW_BITS-1:0]        rpt_row_o,
  output logic [hkrt_pkg::ROW_BITS-1:0]        held_row_o
);

  localparam int unsigned ROW_W = hkrt_pkg::ROW_MAX_W;

  logic [hkrt_pkg::ROW_BITS-1:0] rpt_mem  [ROWS];
  logic [hkrt_pkg::ROW_BITS-1:0] held_mem [ROWS];
  logic [ROWS-1:0]               rvld_q;
  logic [ROWS-1:0]               hvld_q;
  logic [hkrt_pkg::ROW_BITS-1:0] rpt_rd_q;
  logic [hkrt_pkg::ROW_BITS-1:0] held_rd_q;
  logic                          rvld_rd_q;
  logic                          hvld_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.rpt_we) begin
      rpt_mem[req_i.wr_row] <= req_i.wdata;
    end
    if (req_i.held_we) begin
      held_mem[req_i.wr_row] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rpt_rd_q  <= rpt_mem[req_i.rd_row];
      held_rd_q <= held_mem[req_i.rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= '0;
      hvld_q    <= '0;
      rvld_rd_q <= 1'b0;
      hvld_rd_q <= 1'b0;
    end else begin
      if (req_i.rpt_clr) begin
        rvld_q <= '0;
      end else if (req_i.rpt_we) begin
        rvld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.held_we) begin
        hvld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_rd_q <= rvld_q[req_i.rd_row[ROW_W-1:0]];
        hvld_rd_q <= hvld_q[req_i.rd_row[ROW_W-1:0]];
      end
    end
  end

  assign rpt_row_o  = rvld_rd_q ? rpt_rd_q : '0;
  assign held_row_o = hvld_rd_q ? held_rd_q : '0;

endmodule

// ===== rtl/hid_keyboard_report_tracker.sv =====
// HID keyboard report tracker: command sequencer, event output and typematic repeat.
// Begin report clears the report bitmap; a usage is read, then written back; a tick may
// wait for the output. End of report reads each bitmap row of 16 usages twice: to count
// changes, then to load the held row and emit events as the output allows, then closes.
// A new item is taken once the previous one is done; one result per cycle at most.
// Reset is asynchronous and clears both bitmaps at once through row valid flags.
module hid_keyboard_report_tracker #(
  parameter int unsigned USAGE_COUNT = hkrt_pkg::USAGE_COUNT_DEF,
  parameter int unsigned MAX_EVENTS  = hkrt_pkg::MAX_EVENTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hkrt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hkrt_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int unsigned ROWS  = (USAGE_COUNT + hkrt_pkg::ROW_BITS - 1) / hkrt_pkg::ROW_BITS;
  localparam int unsigned ROW_W = hkrt_pkg::ROW_MAX_W;
  localparam int unsigned BIT_W = hkrt_pkg::BIT_W;
  localparam int unsigned CNT_W = $clog2(USAGE_COUNT + 1);
  localparam int unsigned EV_W  = $clog2(MAX_EVENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_REC, S_P1_RD, S_P1_EV, S_P2_RD, S_P2_LD, S_P2_EM, S_FIN, S_TICK
  } state_e;

  state_e                        state_q;
  hkrt_pkg::mem_req_t            req;
  logic [hkrt_pkg::ROW_BITS-1:0] rpt_row, held_row;
  logic [ROW_W-1:0]              row_q;
  logic [BIT_W-1:0]              bit_q;
  logic [15:0]                   delay_q, period_q;
  logic [63:0]                   now_q, deadline_q;
  logic                          armed_q, rep_in_q, have_new_q;
  logic [7:0]                    rep_key_q, new_key_q;
  logic [8:0]                    rep_mods_q;
  logic [5:0]                    mod_bits_q;
  logic [2:0]                    locks_q;
  logic [CNT_W-1:0]              count_q;
  logic [EV_W-1:0]               emit_q;
  logic [hkrt_pkg::ROW_BITS-1:0] mask_q, rptbuf_q;
  logic                          out_valid_q;
  hkrt_pkg::out_t                out_q;

  logic                          accept, out_free, rec_ok, overflow, is_last;
  logic                          ev_fire, rep_fire, out_valid_d;
  logic [EV_W-1:0]               n_tot;
  logic [hkrt_pkg::ROW_BITS-1:0] newp;
  logic [BIT_W-1:0]              ev_bit;
  logic [7:0]                    ev_key;
  hkrt_pkg::keymap_t             ev_map, rep_map;
  logic [8:0]                    mods;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rec_ok   = (in_data_i.page == hkrt_pkg::PAGE_KEYBOARD)
                 && (in_data_i.usage >= hkrt_pkg::USAGE_FIRST)
                 && (in_data_i.usage < 16'(USAGE_COUNT))
                 && ((in_data_i.command == hkrt_pkg::CMD_ARRAY) || in_data_i.usage_on);
  assign overflow = (count_q > CNT_W'(MAX_EVENTS));
  assign n_tot    = overflow ? EV_W'(MAX_EVENTS) : EV_W'(count_q);
  assign is_last  = ((emit_q + EV_W'(1)) == n_tot);
  assign newp     = rpt_row & ~held_row & hkrt_pkg::rep_mask(4'(row_q));
  assign ev_bit   = hkrt_pkg::low_bit(mask_q);
  assign ev_key   = {4'(row_q), ev_bit};
  assign ev_map   = hkrt_pkg::keymap(ev_key);
  assign rep_map  = hkrt_pkg::keymap(rep_key_q);
  assign mods     = {locks_q, mod_bits_q};

  assign ev_fire     = (state_q == S_P2_EM) && (mask_q != '0)
                    && (emit_q != EV_W'(MAX_EVENTS)) && out_free;
  assign rep_fire    = (state_q == S_TICK) && armed_q && (now_q >= deadline_q)
                    && rep_map.valid && out_free;
  assign out_valid_d = ev_fire || rep_fire || (out_valid_q && out_stall_i);

  always_comb begin
    req = '0;
    req.wr_row = 4'(row_q);
    case (state_q)
      S_IDLE: begin
        if (accept && in_data_i.command == hkrt_pkg::CMD_BEGIN) begin
          req.rpt_clr = 1'b1;
        end
        if (accept && rec_ok &&
            (in_data_i.command == hkrt_pkg::CMD_ARRAY ||
             in_data_i.command == hkrt_pkg::CMD_VAR)) begin
          req.rd_en  = 1'b1;
          req.rd_row = in_data_i.usage[7:4];
        end
      end
      S_REC: begin
        req.rpt_we = 1'b1;
        req.wdata  = rpt_row | (hkrt_pkg::ROW_BITS'(1) << bit_q);
      end
      S_P1_RD, S_P2_RD: begin
        req.rd_en  = 1'b1;
        req.rd_row = 4'(row_q);
      end
      S_P2_LD: begin
        req.held_we = 1'b1;
        req.wdata   = rpt_row;
      end
      default: begin
      end
    endcase
  end

  hkrt_keymem #(.ROWS(ROWS)) u_keymem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rpt_row_o  (rpt_row),
    .held_row_o (held_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      bit_q       <= '0;
      delay_q     <= hkrt_pkg::DELAY_RESET;
      period_q    <= hkrt_pkg::PERIOD_RESET;
      now_q       <= '0;
      deadline_q  <= '0;
      armed_q     <= 1'b0;
      rep_in_q    <= 1'b0;
      have_new_q  <= 1'b0;
      rep_key_q   <= '0;
      new_key_q   <= '0;
      rep_mods_q  <= '0;
      mod_bits_q  <= '0;
      locks_q     <= '0;
      count_q     <= '0;
      emit_q      <= '0;
      mask_q      <= '0;
      rptbuf_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hkrt_pkg::REG_DELAY) begin
          delay_q <= cfg_data_i;
        end else begin
          period_q <= cfg_data_i;
        end
      end
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_data_i.command)
              hkrt_pkg::CMD_ARRAY, hkrt_pkg::CMD_VAR: begin
                if (rec_ok) begin
                  row_q   <= ROW_W'(in_data_i.usage[7:4]);
                  bit_q   <= in_data_i.usage[3:0];
                  state_q <= S_REC;
                end
              end
              hkrt_pkg::CMD_END: begin
                row_q      <= '0;
                count_q    <= '0;
                emit_q     <= '0;
                have_new_q <= 1'b0;
                rep_in_q   <= 1'b0;
                mod_bits_q <= '0;
                state_q    <= S_P1_RD;
              end
              hkrt_pkg::CMD_TICK: begin
                now_q   <= now_q + 64'd1;
                state_q <= S_TICK;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_REC: state_q <= S_IDLE;
        S_P1_RD: state_q <= S_P1_EV;
        S_P1_EV: begin
          count_q <= count_q + CNT_W'(hkrt_pkg::pop16((rpt_row ^ held_row)
                                                     & hkrt_pkg::map_mask(4'(row_q))));
          if (newp != '0) begin
            have_new_q <= 1'b1;
            new_key_q  <= {4'(row_q), hkrt_pkg::high_bit(newp)};
          end
          if (4'(row_q) == rep_key_q[7:4]) begin
            rep_in_q <= rpt_row[rep_key_q[3:0]];
          end
          if (4'(row_q) == hkrt_pkg::KEY_LSHIFT[7:4]) begin
            mod_bits_q <= {rpt_row[hkrt_pkg::KEY_RALT[3:0]],
                           rpt_row[hkrt_pkg::KEY_LALT[3:0]],
                           rpt_row[hkrt_pkg::KEY_RCTRL[3:0]],
                           rpt_row[hkrt_pkg::KEY_LCTRL[3:0]],
                           rpt_row[hkrt_pkg::KEY_RSHIFT[3:0]],
                           rpt_row[hkrt_pkg::KEY_LSHIFT[3:0]]};
          end
          if (4'(row_q) == hkrt_pkg::KEY_CAPS[7:4] && rpt_row[hkrt_pkg::KEY_CAPS[3:0]]
              && !held_row[hkrt_pkg::KEY_CAPS[3:0]]) begin
            locks_q[0] <= !locks_q[0];
          end
          if (4'(row_q) == hkrt_pkg::KEY_SCROLL[7:4] && rpt_row[hkrt_pkg::KEY_SCROLL[3:0]]
              && !held_row[hkrt_pkg::KEY_SCROLL[3:0]]) begin
            locks_q[1] <= !locks_q[1];
          end
          if (4'(row_q) == hkrt_pkg::KEY_NUM[7:4] && rpt_row[hkrt_pkg::KEY_NUM[3:0]]
              && !held_row[hkrt_pkg::KEY_NUM[3:0]]) begin
            locks_q[2] <= !locks_q[2];
          end
          if (row_q == ROW_W'(ROWS - 1)) begin
            row_q   <= '0;
            state_q <= S_P2_RD;
          end else begin
            row_q   <= row_q + ROW_W'(1);
            state_q <= S_P1_RD;
          end
        end
        S_P2_RD: state_q <= S_P2_LD;
        S_P2_LD: begin
          mask_q   <= (rpt_row ^ held_row) & hkrt_pkg::map_mask(4'(row_q));
          rptbuf_q <= rpt_row;
          state_q  <= S_P2_EM;
        end
        S_P2_EM: begin
          if (mask_q == '0 || emit_q == EV_W'(MAX_EVENTS)) begin
            if (row_q == ROW_W'(ROWS - 1)) begin
              state_q <= S_FIN;
            end else begin
              row_q   <= row_q + ROW_W'(1);
              state_q <= S_P2_RD;
            end
          end else if (out_free) begin
            out_q.key_group   <= ev_map.group;
            out_q.key_row     <= ev_map.row;
            out_q.key_col     <= ev_map.col;
            out_q.modifiers   <= mods;
            out_q.pressed     <= rptbuf_q[ev_bit];
            out_q.from_repeat <= 1'b0;
            out_q.last        <= is_last;
            out_q.overflow    <= overflow;
            mask_q[ev_bit]    <= 1'b0;
            emit_q            <= emit_q + EV_W'(1);
          end
        end
        S_FIN: begin
          rep_mods_q <= mods;
          if (have_new_q && (!(armed_q && rep_in_q) || rep_key_q != new_key_q)) begin
            armed_q    <= 1'b1;
            rep_key_q  <= new_key_q;
            deadline_q <= now_q + {48'd0, delay_q};
          end else if (!rep_in_q) begin
            armed_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
        S_TICK: begin
          if (armed_q && now_q >= deadline_q && rep_map.valid) begin
            if (out_free) begin
              out_q.key_group   <= rep_map.group;
              out_q.key_row     <= rep_map.row;
              out_q.key_col     <= rep_map.col;
              out_q.modifiers   <= rep_mods_q;
              out_q.pressed     <= 1'b1;
              out_q.from_repeat <= 1'b1;
              out_q.last        <= 1'b1;
              out_q.overflow    <= 1'b0;
              deadline_q        <= deadline_q + {48'd0, period_q};
              state_q           <= S_IDLE;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= EV_W'(MAX_EVENTS))
    else $error("event count passed its limit");

  a_repeat_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.from_repeat |-> out_data_o.last && !out_data_o.overflow)
    else $error("repeat transfer not marked as single last result");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P2_EM) |-> in_stall_o)
    else $error("input taken during event walk");
`endif

endmodule

// ===== sim/hkrt_checker.sv =====
// Checker for the HID keyboard report tracker: predicts key events and compares every transfer.
`timescale 1ns / 1ps
module hkrt_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  hkrt_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  hkrt_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  typedef struct packed {
    logic       valid;
    logic [1:0] group;
    logic [2:0] row;
    logic [4:0] col;
  } key_pos_t;

  logic [255:0]   rep_bits;
  logic [255:0]   held_bits;
  logic [2:0]     lock_bits;
  logic           rpt_on;
  logic [7:0]     rpt_key;
  logic [8:0]     rpt_mods;
  logic [63:0]    rpt_due;
  logic [63:0]    ms_now;
  logic [15:0]    delay_ms;
  logic [15:0]    period_ms;
  hkrt_pkg::out_t event_q[$];

  function automatic key_pos_t kp(input logic [1:0] g, input logic [2:0] r,
                                  input logic [4:0] c);
    kp = {1'b1, g, r, c};
  endfunction

  function automatic key_pos_t key_pos(input logic [7:0] k);
    case (k)
      8'h35: return kp(0, 0, 0);   8'h1E: return kp(0, 0, 1);   8'h1F: return kp(0, 0, 2);
      8'h20: return kp(0, 0, 3);   8'h21: return kp(0, 0, 4);   8'h22: return kp(0, 0, 5);
      8'h23: return kp(0, 0, 6);   8'h24: return kp(0, 0, 7);   8'h25: return kp(0, 0, 8);
      8'h26: return kp(0, 0, 9);   8'h27: return kp(0, 0, 10);  8'h2D: return kp(0, 0, 11);
      8'h2E: return kp(0, 0, 12);  8'h2A: return kp(0, 0, 13);
      8'h2B: return kp(0, 1, 0);   8'h14: return kp(0, 1, 1);   8'h1A: return kp(0, 1, 2);
      8'h08: return kp(0, 1, 3);   8'h15: return kp(0, 1, 4);   8'h17: return kp(0, 1, 5);
      8'h1C: return kp(0, 1, 6);   8'h18: return kp(0, 1, 7);   8'h0C: return kp(0, 1, 8);
      8'h12: return kp(0, 1, 9);   8'h13: return kp(0, 1, 10);  8'h2F: return kp(0, 1, 11);
      8'h30: return kp(0, 1, 12);
      8'h39: return kp(0, 2, 0);   8'h04: return kp(0, 2, 1);   8'h16: return kp(0, 2, 2);
      8'h07: return kp(0, 2, 3);   8'h09: return kp(0, 2, 4);   8'h0A: return kp(0, 2, 5);
      8'h0B: return kp(0, 2, 6);   8'h0D: return kp(0, 2, 7);   8'h0E: return kp(0, 2, 8);
      8'h0F: return kp(0, 2, 9);   8'h33: return kp(0, 2, 10);  8'h34: return kp(0, 2, 11);
      8'h31: return kp(0, 2, 12);  8'h28: return kp(0, 2, 13);
      8'hE1: return kp(0, 3, 0);   8'h64: return kp(0, 3, 1);   8'h1D: return kp(0, 3, 2);
      8'h1B: return kp(0, 3, 3);   8'h06: return kp(0, 3, 4);   8'h19: return kp(0, 3, 5);
      8'h05: return kp(0, 3, 6);   8'h11: return kp(0, 3, 7);   8'h10: return kp(0, 3, 8);
      8'h36: return kp(0, 3, 9);   8'h37: return kp(0, 3, 10);  8'h38: return kp(0, 3, 11);
      8'hE5: return kp(0, 3, 12);
      8'hE0: return kp(0, 4, 0);   8'hE3: return kp(0, 4, 1);   8'hE2: return kp(0, 4, 2);
      8'h2C: return kp(0, 4, 3);   8'hE6: return kp(0, 4, 5);   8'hE4: return kp(0, 4, 6);
      8'h52: return kp(0, 5, 0);   8'h50: return kp(0, 5, 1);   8'h51: return kp(0, 5, 2);
      8'h4F: return kp(0, 5, 3);
      8'h29: return kp(1, 0, 0);   8'h3A: return kp(1, 0, 1);   8'h3B: return kp(1, 0, 2);
      8'h3C: return kp(1, 0, 3);   8'h3D: return kp(1, 0, 4);   8'h3E: return kp(1, 0, 5);
      8'h3F: return kp(1, 0, 6);   8'h40: return kp(1, 0, 7);   8'h41: return kp(1, 0, 8);
      8'h42: return kp(1, 0, 9);   8'h43: return kp(1, 0, 10);  8'h44: return kp(1, 0, 11);
      8'h45: return kp(1, 0, 12);  8'h49: return kp(1, 0, 13);  8'h46: return kp(1, 0, 14);
      8'h4C: return kp(1, 0, 15);  8'h4A: return kp(1, 0, 16);  8'h4D: return kp(1, 0, 17);
      8'h4B: return kp(1, 0, 18);  8'h4E: return kp(1, 0, 19);  8'h47: return kp(1, 0, 20);
      8'h53: return kp(2, 0, 0);   8'h54: return kp(2, 0, 1);   8'h55: return kp(2, 0, 2);
      8'h56: return kp(2, 0, 3);   8'h5F: return kp(2, 1, 0);   8'h60: return kp(2, 1, 1);
      8'h61: return kp(2, 1, 2);   8'h57: return kp(2, 1, 3);   8'h5C: return kp(2, 2, 0);
      8'h5D: return kp(2, 2, 1);   8'h5E: return kp(2, 2, 2);   8'h59: return kp(2, 3, 0);
      8'h5A: return kp(2, 3, 1);   8'h5B: return kp(2, 3, 2);   8'h58: return kp(2, 3, 3);
      8'h62: return kp(2, 4, 0);   8'h63: return kp(2, 4, 1);
      default: return '0;
    endcase
  endfunction

  function automatic logic can_repeat(input int k);
    if (k <= 3 || k == 8'h29 || k == hkrt_pkg::KEY_CAPS || k == hkrt_pkg::KEY_SCROLL
        || k == hkrt_pkg::KEY_NUM) return 0;
    if (k >= 8'h3A && k <= 8'h45) return 0;
    if (k >= 8'hE0 && k <= 8'hE7) return 0;
    return 1;
  endfunction

  function automatic hkrt_pkg::out_t key_event(input logic [7:0] k, input logic [8:0] mods,
                                               input logic down, input logic rep);
    key_pos_t p;
    hkrt_pkg::out_t e;
    p = key_pos(k);
    e = '0;
    e.key_group = p.group;
    e.key_row = p.row;
    e.key_col = p.col;
    e.modifiers = mods;
    e.pressed = down;
    e.from_repeat = rep;
    return e;
  endfunction

  task automatic predict_end_of_report();
    hkrt_pkg::out_t evs[$];
    logic [8:0] mods;
    logic dropped, fresh;
    int new_key;
    mods = '0;
    dropped = 0;
    fresh = 0;
    new_key = 0;
    mods[0] = rep_bits[hkrt_pkg::KEY_LSHIFT];
    mods[1] = rep_bits[hkrt_pkg::KEY_RSHIFT];
    mods[2] = rep_bits[hkrt_pkg::KEY_LCTRL];
    mods[3] = rep_bits[hkrt_pkg::KEY_RCTRL];
    mods[4] = rep_bits[hkrt_pkg::KEY_LALT];
    mods[5] = rep_bits[hkrt_pkg::KEY_RALT];
    if (rep_bits[hkrt_pkg::KEY_CAPS] && !held_bits[hkrt_pkg::KEY_CAPS])
      lock_bits[0] = ~lock_bits[0];
    if (rep_bits[hkrt_pkg::KEY_SCROLL] && !held_bits[hkrt_pkg::KEY_SCROLL])
      lock_bits[1] = ~lock_bits[1];
    if (rep_bits[hkrt_pkg::KEY_NUM] && !held_bits[hkrt_pkg::KEY_NUM])
      lock_bits[2] = ~lock_bits[2];
    mods[8:6] = lock_bits;
    for (int i = 0; i < 256; i++) begin
      if (rep_bits[i] != held_bits[i]) begin
        if (rep_bits[i] && can_repeat(i)) begin
          fresh = 1;
          new_key = i;
        end
        if (key_pos(8'(i)).valid) begin
          if (evs.size() < hkrt_pkg::MAX_EVENTS_DEF)
            evs.push_back(key_event(8'(i), mods, rep_bits[i], 0));
          else dropped = 1;
        end
        held_bits[i] = rep_bits[i];
      end
    end
    if (rpt_on && !rep_bits[rpt_key]) rpt_on = 0;
    rpt_mods = mods;
    if (fresh && (!rpt_on || rpt_key != 8'(new_key))) begin
      rpt_on = 1;
      rpt_key = 8'(new_key);
      rpt_due = ms_now + 64'(delay_ms);
    end
    foreach (evs[k]) begin
      evs[k].overflow = dropped;
      evs[k].last = (k == evs.size() - 1);
      event_q.push_back(evs[k]);
    end
  endtask

  task automatic predict_item(input hkrt_pkg::in_t it);
    hkrt_pkg::out_t e;
    case (it.command)
      hkrt_pkg::CMD_BEGIN: rep_bits = '0;
      hkrt_pkg::CMD_ARRAY, hkrt_pkg::CMD_VAR: begin
        if ((it.command == hkrt_pkg::CMD_ARRAY || it.usage_on)
            && it.page == hkrt_pkg::PAGE_KEYBOARD
            && it.usage >= hkrt_pkg::USAGE_FIRST && it.usage < 16'd256)
          rep_bits[it.usage[7:0]] = 1;
      end
      hkrt_pkg::CMD_END: predict_end_of_report();
      hkrt_pkg::CMD_TICK: begin
        ms_now = ms_now + 1;
        if (rpt_on && ms_now >= rpt_due && key_pos(rpt_key).valid) begin
          e = key_event(rpt_key, rpt_mods, 1, 1);
          e.last = 1;
          event_q.push_back(e);
          rpt_due = rpt_due + 64'(period_ms);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hkrt_pkg::out_t want;
    if (!rst_ni) begin
      rep_bits = '0;
      held_bits = '0;
      lock_bits = '0;
      rpt_on = 0;
      rpt_key = '0;
      rpt_mods = '0;
      rpt_due = '0;
      ms_now = '0;
      delay_ms = hkrt_pkg::DELAY_RESET;
      period_ms = hkrt_pkg::PERIOD_RESET;
      event_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hkrt_pkg::REG_DELAY) delay_ms = cfg_data_i;
        else period_ms = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (event_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $realtime, out_data_i);
          fail_count_o++;
        end else begin
          want = event_q.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: mismatch, expected %h, actual %h", $realtime, want, out_data_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      pending_o = event_q.size();
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top of the HID keyboard report tracker: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;

  logic           clk_i = 0;
  logic           rst_ni = 0;
  logic           in_valid = 0;
  logic           in_stall;
  hkrt_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 0;
  hkrt_pkg::out_t out_data;
  logic           cfg_we = 0;
  logic           cfg_idx = 0;
  logic [15:0]    cfg_data = '0;
  int             fail_count;
  int             pending;
  int             quiet_cycles = 0;
  int             item_count = 0;
  int             phase_cycle = 0;
  bit             no_idle = 0;
  bit             hold_off = 0;
  bit             hold_done = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  hid_keyboard_report_tracker dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  hkrt_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random, except during a quiet stretch or a long hold-off.
  always @(negedge clk_i) begin
    int held;
    if (hold_off && !hold_done) begin
      out_stall <= 1;
      held = 0;
      while (held < 400) begin
        @(negedge clk_i);
        held++;
      end
      hold_done = 1;
      out_stall <= 0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send(input hkrt_pkg::cmd_e cmd, input logic [15:0] page,
                      input logic [15:0] usage, input logic on);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(negedge clk_i);
    end
    in_valid <= 1;
    in_data <= {cmd, page, usage, on};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    item_count++;
  endtask

  task automatic press(input logic [15:0] usage);
    send(hkrt_pkg::CMD_ARRAY, hkrt_pkg::PAGE_KEYBOARD, usage, 1'($urandom_range(1)));
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    int spare;
    spare = 0;
    in_valid <= 0;
    while (pending != 0) @(negedge clk_i);
    while (spare < 400) begin
      @(negedge clk_i);
      spare++;
    end
  endtask

  task automatic random_report(input int keys);
    int u;
    send(hkrt_pkg::CMD_BEGIN, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    repeat (keys) begin
      u = $urandom_range(99) < 80 ? $urandom_range(4, 255) : $urandom_range(0, 65535);
      case ($urandom_range(9))
        0: send(hkrt_pkg::CMD_ARRAY, 16'($urandom), 16'(u), 1'($urandom_range(1)));
        1, 2: send(hkrt_pkg::CMD_VAR, hkrt_pkg::PAGE_KEYBOARD, 16'(u), 1'($urandom_range(1)));
        default: press(16'(u));
      endcase
    end
    send(hkrt_pkg::CMD_END, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    write_reg(hkrt_pkg::REG_DELAY, 16'd3);
    write_reg(hkrt_pkg::REG_PERIOD, 16'd2);
    // Directed part: locks, modifiers, repeat, page and range edges, unused commands.
    send(hkrt_pkg::CMD_BEGIN, 0, 0, 0);
    press(16'h39); press(16'h47); press(16'h53); press(16'hE1); press(16'hE4);
    send(hkrt_pkg::CMD_ARRAY, hkrt_pkg::PAGE_KEYBOARD, 16'd3, 1);
    send(hkrt_pkg::CMD_ARRAY, 16'hFFFF, 16'h04, 1);
    send(hkrt_pkg::CMD_VAR, hkrt_pkg::PAGE_KEYBOARD, 16'h04, 0);
    send(hkrt_pkg::CMD_VAR, hkrt_pkg::PAGE_KEYBOARD, 16'h05, 1);
    send(hkrt_pkg::CMD_ARRAY, hkrt_pkg::PAGE_KEYBOARD, 16'hFFFF, 1);
    press(16'd255);
    send(hkrt_pkg::CMD_END, 0, 0, 0);
    repeat (5) send(hkrt_pkg::CMD_TICK, 0, 0, 0);
    send(hkrt_pkg::cmd_e'(3'd5), hkrt_pkg::PAGE_KEYBOARD, 16'h04, 1);
    send(hkrt_pkg::cmd_e'(3'd7), 16'hFFFF, 16'hFFFF, 1);
    send(hkrt_pkg::CMD_BEGIN, 0, 0, 0);
    send(hkrt_pkg::CMD_END, 0, 0, 0);
    send(hkrt_pkg::CMD_END, 0, 0, 0);
    // More mapped keys at once than the event limit allows.
    send(hkrt_pkg::CMD_BEGIN, 0, 0, 0);
    for (int u = 4; u < 'h53; u++) press(16'(u));
    send(hkrt_pkg::CMD_END, 0, 0, 0);
    send(hkrt_pkg::CMD_BEGIN, 0, 0, 0);
    send(hkrt_pkg::CMD_END, 0, 0, 0);
    drain();
    write_reg(hkrt_pkg::REG_DELAY, 16'd0);
    write_reg(hkrt_pkg::REG_PERIOD, 16'd0);
    item_count = 0;
    while (item_count < 200) begin
      if (item_count > 40 && item_count < 100) no_idle = 1;
      else no_idle = 0;
      if (item_count > 120 && phase_cycle == 0) begin
        drain();
        write_reg(hkrt_pkg::REG_DELAY, 16'hFFFF);
        write_reg(hkrt_pkg::REG_PERIOD, 16'hFFFF);
        phase_cycle = 1;
      end else if (item_count > 160 && phase_cycle == 1) begin
        drain();
        write_reg(hkrt_pkg::REG_DELAY, 16'd1);
        write_reg(hkrt_pkg::REG_PERIOD, 16'd1);
        hold_off = 1;
        phase_cycle = 2;
      end
      if ($urandom_range(3) == 0)
        send(hkrt_pkg::cmd_e'(3'($urandom_range(7))), 16'($urandom), 16'($urandom),
             1'($urandom_range(1)));
      else random_report($urandom_range(0, 6));
      repeat ($urandom_range(0, 4))
        send(hkrt_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    end
    no_idle = 0;
    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
